>>> rtl/life_generation_step_torus_macros.svh
// Assertion macros used by the checker file.
`ifndef LIFE_GENERATION_STEP_TORUS_MACROS_SVH
`define LIFE_GENERATION_STEP_TORUS_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LGST_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LGST_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/lgst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lgst_pkg;

  // Grid geometry.
  localparam int NumRows = 64;
  localparam int NumCols = 64;
  localparam int RowW    = $clog2(NumRows);
  localparam int ColW    = $clog2(NumCols);
  localparam int SizeW   = 7;
  localparam int KindW   = 2;
  localparam int IdxW    = 2;

  // Configuration register indexes.
  localparam logic [IdxW-1:0] CfgRows = 2'd0;
  localparam logic [IdxW-1:0] CfgCols = 2'd1;

  typedef enum logic [KindW-1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_STEP  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_G_LAST,
    ST_G_FIRST,
    ST_G_READ,
    ST_G_CALC
  } state_e;

  // Which row address the memory read port gets.
  typedef enum logic [2:0] {
    RD_NONE,
    RD_IN_ROW,
    RD_LAST,
    RD_ZERO,
    RD_NEXT
  } rd_sel_e;

  typedef struct packed {
    logic    cap;
    rd_sel_e rd_sel;
    logic    wr_cell;
    logic    wr_gen;
    logic    ld_prev;
    logic    ld_first;
    logic    adv;
    logic    strobe;
  } ctrl_t;

  typedef struct packed {
    logic in_inside;
    logic last_row;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/lgst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lgst_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lgst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module lgst_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [lgst_pkg::KindW-1:0] kind_i,
  input  wire lgst_pkg::status_t          status_i,
  output lgst_pkg::ctrl_t                 ctrl_o,
  output logic                            busy_o
);
  import lgst_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.rd_sel = RD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ctrl_o.cap = 1'b1;
          unique case (kind_e'(kind_i))
            KIND_WRITE: begin
              if (status_i.in_inside) begin
                ctrl_o.rd_sel = RD_IN_ROW;
                state_d = ST_WRITE;
              end
            end
            KIND_READ: begin
              ctrl_o.rd_sel = RD_IN_ROW;
              state_d = ST_READ;
            end
            KIND_STEP: begin
              ctrl_o.rd_sel = RD_LAST;
              state_d = ST_G_LAST;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_WRITE: begin
        ctrl_o.wr_cell = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ: begin
        ctrl_o.strobe = 1'b1;
        state_d = ST_IDLE;
      end
      ST_G_LAST: begin
        ctrl_o.ld_prev = 1'b1;
        ctrl_o.rd_sel = RD_ZERO;
        state_d = ST_G_FIRST;
      end
      ST_G_FIRST: begin
        ctrl_o.ld_first = 1'b1;
        state_d = ST_G_READ;
      end
      ST_G_READ: begin
        ctrl_o.rd_sel = RD_NEXT;
        state_d = ST_G_CALC;
      end
      ST_G_CALC: begin
        ctrl_o.wr_gen = 1'b1;
        ctrl_o.adv = 1'b1;
        state_d = status_i.last_row ? ST_IDLE : ST_G_READ;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/lgst_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module lgst_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire lgst_pkg::ctrl_t             ctrl_i,
  output lgst_pkg::status_t                status_o,
  input  wire logic [lgst_pkg::RowW-1:0]   row_i,
  input  wire logic [lgst_pkg::ColW-1:0]   col_i,
  input  wire logic                        cell_in_i,
  input  wire logic                        cfg_we_i,
  input  wire logic [lgst_pkg::IdxW-1:0]   cfg_index_i,
  input  wire logic [lgst_pkg::SizeW-1:0]  cfg_data_i,
  output logic                             valid_o,
  output logic                             cell_out_o
);
  import lgst_pkg::*;

  localparam logic [SizeW-1:0] RowsMax = SizeW'(NumRows);
  localparam logic [SizeW-1:0] ColsMax = SizeW'(NumCols);

  logic [SizeW-1:0]   nr_q, nc_q, cfg_clamped;
  logic [RowW-1:0]    row_q, r_q, raddr_q, raddr;
  logic [ColW-1:0]    col_q;
  logic               cell_q, inside_q;
  logic [NumRows-1:0] valid_q;
  logic [NumCols-1:0] prev_q, cur_q, first_q;
  logic [NumCols-1:0] rdata, row_data, next_row, cell_row, gen_row;
  logic               re;
  logic               we;
  logic [RowW-1:0]    waddr;
  logic [NumCols-1:0] wdata;
  logic [ColW-1:0]    nc_last;
  logic               in_inside;

  // Clamp a size written over the configuration port to the legal range.
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_clamped = SizeW'(1);
    end else if (cfg_data_i > RowsMax) begin
      cfg_clamped = RowsMax;
    end else begin
      cfg_clamped = cfg_data_i;
    end
  end

  // Size registers; both maxima equal, so one clamp serves.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nr_q <= RowsMax;
      nc_q <= ColsMax;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgRows) begin
        nr_q <= cfg_clamped;
      end else if (cfg_index_i == CfgCols) begin
        nc_q <= cfg_clamped;
      end
    end
  end

  assign in_inside = ({1'b0, row_i} < nr_q) && ({1'b0, col_i} < nc_q);
  assign status_o.in_inside = in_inside;
  assign status_o.last_row  = ({1'b0, r_q} == (nr_q - SizeW'(1)));

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      row_q    <= row_i;
      col_q    <= col_i;
      cell_q   <= cell_in_i;
      inside_q <= in_inside;
    end
  end

  // Read address selection.
  always_comb begin
    re    = 1'b1;
    raddr = '0;
    unique case (ctrl_i.rd_sel)
      RD_IN_ROW: raddr = row_i;
      RD_LAST:   raddr = RowW'(nr_q - SizeW'(1));
      RD_ZERO:   raddr = '0;
      RD_NEXT:   raddr = r_q + RowW'(1);
      default:   re = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      raddr_q <= raddr;
    end
  end

  // Rows never written since reset read as all dead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  assign row_data = valid_q[raddr_q] ? rdata : '0;

  // Single cell update of the fetched row.
  always_comb begin
    cell_row = row_data;
    cell_row[col_q] = cell_q;
  end

  // Row below the current one: the saved old row 0 wraps in at the bottom.
  assign next_row = status_o.last_row ? first_q : row_data;
  assign nc_last  = ColW'(nc_q - SizeW'(1));

  // New generation of one row, all columns side by side.
  always_comb begin
    logic       lb, rb;
    logic [3:0] cnt;
    for (int c = 0; c < NumCols; c++) begin
      if (c == 0) begin
        lb = 1'b0;
      end else begin
        lb = 1'b0;
      end
      cnt = '0;
      if (c == 0) begin
        cnt = 4'(prev_q[nc_last]) + 4'(cur_q[nc_last]) + 4'(next_row[nc_last]);
      end else begin
        cnt = 4'(prev_q[c-1]) + 4'(cur_q[c-1]) + 4'(next_row[c-1]);
      end
      rb = (c + 1 >= int'(nc_q));
      if (rb || c == NumCols - 1) begin
        cnt = cnt + 4'(prev_q[0]) + 4'(cur_q[0]) + 4'(next_row[0]);
      end else begin
        cnt = cnt + 4'(prev_q[c+1]) + 4'(cur_q[c+1]) + 4'(next_row[c+1]);
      end
      cnt = cnt + 4'(prev_q[c]) + 4'(next_row[c]) + 4'(lb);
      if (c >= int'(nc_q)) begin
        gen_row[c] = cur_q[c];
      end else if (cur_q[c]) begin
        gen_row[c] = (cnt == 4'd2) || (cnt == 4'd3);
      end else begin
        gen_row[c] = (cnt == 4'd3);
      end
    end
  end

  // Sliding window of old rows during a generation step.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_prev) begin
      prev_q <= row_data;
    end
    if (ctrl_i.ld_first) begin
      cur_q   <= row_data;
      first_q <= row_data;
    end
    if (ctrl_i.adv) begin
      prev_q <= cur_q;
      cur_q  <= next_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q <= '0;
    end else if (ctrl_i.ld_first) begin
      r_q <= '0;
    end else if (ctrl_i.adv) begin
      r_q <= r_q + RowW'(1);
    end
  end

  // Memory write port.
  assign we    = ctrl_i.wr_cell | ctrl_i.wr_gen;
  assign waddr = ctrl_i.wr_gen ? r_q : row_q;
  assign wdata = ctrl_i.wr_gen ? gen_row : cell_row;

  lgst_ram #(
    .Width(NumCols),
    .Depth(NumRows)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Read result.
  assign valid_o    = ctrl_i.strobe;
  assign cell_out_o = inside_q & row_data[col_q];

endmodule

`default_nettype wire

>>> rtl/life_generation_step_torus.sv
// Write request: busy in ST_WRITE (not busy if outside the size in use). Read request: busy
// in ST_READ, and the result strobe comes in that state, right after the request is taken.
// Generation step: busy in ST_G_LAST, ST_G_FIRST, then ST_G_READ and ST_G_CALC per row in use,
// with one grid memory row read and one write per row. One request at a time; the receiver
// cannot stall and takes each result in its strobe cycle. Size writes are taken only when idle.
// Reset (asynchronous, active low) makes every cell dead at once and sets both sizes to 64.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_step_torus (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [lgst_pkg::KindW-1:0]  kind_i,
  input  wire logic [lgst_pkg::RowW-1:0]   row_i,
  input  wire logic [lgst_pkg::ColW-1:0]   col_i,
  input  wire logic                        cell_in_i,
  output logic                             valid_o,
  output logic                             cell_out_o,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [lgst_pkg::IdxW-1:0]   cfg_index_i,
  input  wire logic [lgst_pkg::SizeW-1:0]  cfg_data_i
);
  import lgst_pkg::*;

  ctrl_t   ctrl;
  status_t status;

  // Sizes may only change while no request is in flight.
  assign cfg_ready = ~busy;

  lgst_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .kind_i   (kind_i),
    .status_i (status),
    .ctrl_o   (ctrl),
    .busy_o   (busy)
  );

  lgst_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .row_i       (row_i),
    .col_i       (col_i),
    .cell_in_i   (cell_in_i),
    .cfg_we_i    (cfg_valid & cfg_ready),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_o     (valid_o),
    .cell_out_o  (cell_out_o)
  );

endmodule

`default_nettype wire

>>> rtl/lgst_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "life_generation_step_torus_macros.svh"

module lgst_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [lgst_pkg::KindW-1:0] kind_i,
  input wire logic                       valid_o
);
  import lgst_pkg::*;

  // A read request always yields a result in the next cycle.
  `LGST_ASSERT_NXT(a_read_result, start && !busy && kind_i == KIND_READ, valid_o, "read lost")
  // Results never come back to back.
  `LGST_ASSERT_NXT(a_no_double, valid_o, !valid_o, "repeated result")
  // A result is shown only while the block is busy with the read.
  `LGST_ASSERT_IMP(a_result_busy, valid_o, busy, "result outside a read")
  // A generation step keeps the block busy.
  `LGST_ASSERT_NXT(a_step_busy, start && !busy && kind_i == KIND_STEP, busy, "step not taken")

endmodule

bind life_generation_step_torus lgst_checker u_lgst_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .kind_i  (kind_i),
  .valid_o (valid_o)
);

`default_nettype wire

>>> tb/sv/life_generation_step_torus_tb.sv
`timescale 1ns / 1ps

module life_generation_step_torus_tb;
  import lgst_pkg::*;

  localparam int CycleLimit = 400000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [KindW-1:0]  kind_i = '0;
  logic [RowW-1:0]   row_i = '0;
  logic [ColW-1:0]   col_i = '0;
  logic              cell_in_i = 1'b0;
  logic              valid_o;
  logic              cell_out_o;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IdxW-1:0]   cfg_index_i = '0;
  logic [SizeW-1:0]  cfg_data_i = '0;

  // Predicted grid and sizes.
  logic [NumCols-1:0] grid_q [NumRows];
  logic [SizeW-1:0]   rows_reg, cols_reg;
  logic               read_values_q [$];
  int                 fail_count = 0;
  int                 cycle_count = 0;

  life_generation_step_torus dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int clamp_size(logic [SizeW-1:0] v, int max);
    if (v < 1) return 1;
    if (v > max) return max;
    return v;
  endfunction

  // One generation of B3/S23 over the region in use, wrapping at its edges.
  function automatic void predict_generation();
    logic [NumCols-1:0] nxt [NumRows];
    int nr, nc, cnt, rr, cc;
    nr = clamp_size(rows_reg, NumRows);
    nc = clamp_size(cols_reg, NumCols);
    nxt = grid_q;
    for (int r = 0; r < nr; r++) begin
      for (int c = 0; c < nc; c++) begin
        cnt = 0;
        for (int a = -1; a <= 1; a++) begin
          for (int b = -1; b <= 1; b++) begin
            if (a == 0 && b == 0) continue;
            rr = (r + a + nr) % nr;
            cc = (c + b + nc) % nc;
            cnt += grid_q[rr][cc];
          end
        end
        nxt[r][c] = grid_q[r][c] ? (cnt == 2 || cnt == 3) : (cnt == 3);
      end
    end
    grid_q = nxt;
  endfunction

  function automatic void predict_request(kind_e k, int r, int c, logic v);
    logic in_region;
    in_region = (r < clamp_size(rows_reg, NumRows)) && (c < clamp_size(cols_reg, NumCols));
    case (k)
      KIND_WRITE: if (in_region) grid_q[r][c] = v;
      KIND_READ: read_values_q.push_back(in_region ? grid_q[r][c] : 1'b0);
      KIND_STEP: predict_generation();
      default: ;
    endcase
  endfunction

  // Result checker.
  always @(posedge clk_i) begin
    logic exp_cell;
    cycle_count <= cycle_count + 1;
    if (rst_ni && valid_o) begin
      if (read_values_q.size() == 0) begin
        $error("unexpected result, cell_out %0b", cell_out_o);
        fail_count++;
      end else begin
        exp_cell = read_values_q.pop_front();
        if (cell_out_o !== exp_cell) begin
          $error("cell_out expected %0b actual %0b", exp_cell, cell_out_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  int burst_left = 0;

  // Sends one request; start stays high within a burst and drops for the gap after it.
  task automatic send_request(kind_e k, int r, int c, logic v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    start     <= 1'b1;
    kind_i    <= k;
    row_i     <= RowW'(r);
    col_i     <= ColW'(c);
    cell_in_i <= v;
    do @(posedge clk_i); while (busy);
    predict_request(k, r, c, v);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    if (burst_left != 0) begin
      start <= 1'b0;
      burst_left = 0;
    end
    while (read_values_q.size() != 0) @(posedge clk_i);
    repeat (140) @(posedge clk_i);
  endtask

  task automatic write_size(logic [IdxW-1:0] idx, logic [SizeW-1:0] val);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == CfgRows) rows_reg = val; else cols_reg = val;
  endtask

  task automatic set_sizes(logic [SizeW-1:0] r, logic [SizeW-1:0] c);
    drain();
    write_size(CfgRows, r);
    write_size(CfgCols, c);
    cfg_valid <= 1'b0;
  endtask

  // Field extremes, every kind, a blinker at full size.
  task automatic test_directed();
    send_request(KIND_READ, 63, 63, 1'b0);
    send_request(KIND_WRITE, 0, 0, 1'b1);
    send_request(KIND_WRITE, 63, 63, 1'b1);
    send_request(KIND_READ, 0, 0, 1'b0);
    send_request(KIND_READ, 63, 63, 1'b0);
    send_request(KIND_WRITE, 63, 63, 1'b0);
    send_request(KIND_NONE, 21, 42, 1'b1);
    send_request(KIND_WRITE, 5, 10, 1'b1);
    send_request(KIND_WRITE, 5, 11, 1'b1);
    send_request(KIND_WRITE, 5, 12, 1'b1);
    send_request(KIND_STEP, 0, 0, 1'b0);
    send_request(KIND_READ, 4, 11, 1'b0);
    send_request(KIND_READ, 5, 10, 1'b0);
    send_request(KIND_READ, 6, 11, 1'b0);
    send_request(KIND_STEP, 42, 21, 1'b1);
    send_request(KIND_READ, 5, 12, 1'b0);
  endtask

  // Tiny and out-of-range sizes: self-neighbor counting and clamping.
  task automatic test_size_extremes();
    set_sizes(7'd1, 7'd1);
    send_request(KIND_STEP, 0, 0, 1'b0);
    send_request(KIND_READ, 0, 0, 1'b0);
    send_request(KIND_WRITE, 1, 0, 1'b1);
    send_request(KIND_READ, 0, 1, 1'b0);
    set_sizes(7'd0, 7'd127);
    send_request(KIND_READ, 0, 63, 1'b0);
    send_request(KIND_STEP, 0, 0, 1'b0);
    send_request(KIND_READ, 0, 0, 1'b0);
    set_sizes(7'd2, 7'd2);
    send_request(KIND_WRITE, 1, 1, 1'b1);
    send_request(KIND_STEP, 0, 0, 1'b0);
    send_request(KIND_READ, 1, 1, 1'b0);
  endtask

  // Random requests within one size setting, mostly near the region in use.
  task automatic run_random(int n);
    int nr, nc, r, c, pick;
    nr = clamp_size(rows_reg, NumRows);
    nc = clamp_size(cols_reg, NumCols);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, nr - 1);
      c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, nc - 1);
      if (pick < 45) send_request(KIND_WRITE, r, c, $urandom_range(0, 3) != 0);
      else if (pick < 85) send_request(KIND_READ, r, c, 1'($urandom_range(0, 1)));
      else if (pick < 97) send_request(KIND_STEP, r, c, 1'($urandom_range(0, 1)));
      else send_request(KIND_NONE, r, c, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random();
    set_sizes(7'd5, 7'd6);
    run_random(30);
    set_sizes(7'd3, 7'd64);
    run_random(25);
    set_sizes(7'd64, 7'd3);
    run_random(25);
    set_sizes(7'd9, 7'd12);
    run_random(30);
  endtask

  initial begin
    for (int r = 0; r < NumRows; r++) grid_q[r] = '0;
    rows_reg = 7'd64;
    cols_reg = 7'd64;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_size_extremes();
    test_random();
    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
